// File: src/rfcp_pkg.sv
package rfcp_pkg;

  localparam int POS_W     = 15;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int WIDX_W    = POS_W - BIT_W;
  localparam int CFG_W     = 15;
  localparam int OUT_W     = 14;
  localparam int RAND_W    = 31;
  localparam int DIV_W     = 32;
  localparam int DSTEP_W   = 4;
  localparam int NWR_W     = WIDX_W + 1;

  localparam logic [DSTEP_W-1:0]   DIV_LAST = 4'd15;
  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  localparam logic OP_PICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_REGION     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD,
    ST_SCAN,
    ST_SPLIT
  } state_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [CFG_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: src/rfcp_div.sv
module rfcp_div (
  input  logic               clk,
  input  logic               rst,
  input  rfcp_pkg::div_req_t req,
  output rfcp_pkg::div_rsp_t rsp
);

  logic                           active;
  logic                           done;
  logic [rfcp_pkg::DSTEP_W-1:0]   cnt;
  logic [rfcp_pkg::DIV_W-1:0]     dq;
  logic [rfcp_pkg::CFG_W-1:0]     rem;
  logic [rfcp_pkg::CFG_W-1:0]     dvs;
  logic [rfcp_pkg::DIV_W-1:0]     dq_next;
  logic [rfcp_pkg::CFG_W-1:0]     rem_next;
  logic [rfcp_pkg::CFG_W:0]       r;

  // two restoring steps per cycle
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    r        = '0;
    for (int k = 0; k < 2; k++) begin
      r       = {rem_next, dq_next[rfcp_pkg::DIV_W-1]};
      dq_next = {dq_next[rfcp_pkg::DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r          = r - {1'b0, dvs};
        dq_next[0] = 1'b1;
      end
      rem_next = r[rfcp_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == rfcp_pkg::DIV_LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      dq  <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (active) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule

// File: src/random_free_cell_picker.sv
// channel   | handshake                | word
// ----------+--------------------------+-----------------------------------------
// command   | start, busy              | opcode, random_value
// result    | done (one-cycle strobe)  | cell_index, column, row, none_free
// config    | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// A pick runs the start modulo, then W word reads of the visited map (32 cells a word,
// 1 <= W <= ceil(region/32) + 1), then the column/row split; busy is high throughout.
// A zero line width skips the split; an empty region ends the pick after the modulo.
// A clear holds busy while it writes all ceil(MAX_CELLS/32) map words, one per cycle.
// After reset the same pass over all map words runs with busy high.
// The result strobe lasts one cycle and cannot be held off; a new start is taken then.
module random_free_cell_picker #(
  parameter int MAX_CELLS = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [rfcp_pkg::RAND_W-1:0]   random_value,
  output logic                          done,
  output logic [rfcp_pkg::OUT_W-1:0]    cell_index,
  output logic [rfcp_pkg::OUT_W-1:0]    column,
  output logic [rfcp_pkg::OUT_W-1:0]    row,
  output logic                          none_free,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rfcp_pkg::CFG_W-1:0]    cfg_data
);

  localparam int NW  = (MAX_CELLS + rfcp_pkg::WORD_BITS - 1) / rfcp_pkg::WORD_BITS;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [31:0]    MAXC     = MAX_CELLS;
  localparam logic [WAW-1:0] CLR_LAST = WAW'(NW - 1);

  rfcp_pkg::state_t state, state_next;

  logic [rfcp_pkg::CFG_W-1:0]     line_width;
  logic [rfcp_pkg::CFG_W-1:0]     region_cells;
  logic [rfcp_pkg::CFG_W-1:0]     region_eff;
  logic [rfcp_pkg::CFG_W-1:0]     region_m1;
  logic [rfcp_pkg::CFG_W:0]       region_rnd;
  logic [rfcp_pkg::NWR_W-1:0]     nwr;
  logic [rfcp_pkg::WIDX_W-1:0]    lastw;

  logic [rfcp_pkg::WIDX_W-1:0]    widx, widx_next, widx_adv;
  logic [rfcp_pkg::BIT_W-1:0]     bstart, bstart_next;
  logic [rfcp_pkg::NWR_W-1:0]     cnt, cnt_next;
  logic                           first, first_next;
  logic [rfcp_pkg::POS_W-1:0]     pos, pos_next, pos_found;
  logic [WAW-1:0]                 clr_addr, clr_addr_next;
  logic                           clr_reply, clr_reply_next;

  logic [rfcp_pkg::WORD_BITS-1:0] mem [NW];
  logic [rfcp_pkg::WORD_BITS-1:0] rdata;
  logic [WAW-1:0]                 raddr;
  logic                           mem_we;
  logic [WAW-1:0]                 mem_waddr;
  logic [rfcp_pkg::WORD_BITS-1:0] mem_wdata;

  logic [rfcp_pkg::WORD_BITS-1:0] smask, lmask, cand;
  logic [rfcp_pkg::BIT_W-1:0]     fbit;

  logic                           emit;
  logic [rfcp_pkg::OUT_W-1:0]     o_idx, o_col, o_row;
  logic                           o_none;

  rfcp_pkg::div_req_t div_req;
  rfcp_pkg::div_rsp_t div_rsp;

  rfcp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != rfcp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 15'd128;
      region_cells <= 15'd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfcp_pkg::REG_LINE_WIDTH: line_width   <= cfg_data;
        rfcp_pkg::REG_REGION:     region_cells <= cfg_data;
        default:                  line_width   <= line_width;
      endcase
    end
  end

  always_comb begin
    if (32'(region_cells) > MAXC) begin
      region_eff = rfcp_pkg::CFG_W'(MAXC);
    end else begin
      region_eff = region_cells;
    end
  end

  assign region_m1  = region_eff - 1'b1;
  assign region_rnd = {1'b0, region_eff} + 16'd31;
  assign nwr        = region_rnd[rfcp_pkg::CFG_W:rfcp_pkg::BIT_W];
  assign lastw      = region_m1[rfcp_pkg::POS_W-1:rfcp_pkg::BIT_W];
  assign widx_adv   = (widx == lastw) ? '0 : widx + 1'b1;

  always_comb begin
    smask = first ? (rfcp_pkg::ALL_ONES << bstart) : rfcp_pkg::ALL_ONES;
    if (widx == lastw) begin
      lmask = rfcp_pkg::ALL_ONES >> (5'd31 - region_m1[rfcp_pkg::BIT_W-1:0]);
    end else begin
      lmask = rfcp_pkg::ALL_ONES;
    end
    cand = ~rdata & smask & lmask;
    fbit = '0;
    for (int i = rfcp_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        fbit = rfcp_pkg::BIT_W'(i);
      end
    end
    pos_found = {widx, fbit};
  end

  always_comb begin
    state_next     = state;
    widx_next      = widx;
    bstart_next    = bstart;
    cnt_next       = cnt;
    first_next     = first;
    pos_next       = pos;
    clr_addr_next  = clr_addr;
    clr_reply_next = clr_reply;
    div_req        = '0;
    raddr          = WAW'(widx);
    mem_we         = 1'b0;
    mem_waddr      = WAW'(widx);
    mem_wdata      = rdata;
    emit           = 1'b0;
    o_idx          = '0;
    o_col          = '0;
    o_row          = '0;
    o_none         = 1'b0;
    unique case (state)
      rfcp_pkg::ST_IDLE: begin
        if (start) begin
          if (opcode == rfcp_pkg::OP_CLEAR) begin
            clr_addr_next  = '0;
            clr_reply_next = 1'b1;
            state_next     = rfcp_pkg::ST_CLEAR;
          end else begin
            div_req.go       = 1'b1;
            div_req.dividend = rfcp_pkg::DIV_W'(random_value);
            div_req.divisor  = region_eff;
            state_next       = rfcp_pkg::ST_MOD;
          end
        end
      end
      rfcp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == CLR_LAST) begin
          emit           = clr_reply;
          clr_reply_next = 1'b0;
          state_next     = rfcp_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      rfcp_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          if (region_eff == '0) begin
            emit       = 1'b1;
            o_none     = 1'b1;
            state_next = rfcp_pkg::ST_IDLE;
          end else begin
            widx_next   = div_rsp.rem[rfcp_pkg::POS_W-1:rfcp_pkg::BIT_W];
            bstart_next = div_rsp.rem[rfcp_pkg::BIT_W-1:0];
            raddr       = WAW'(div_rsp.rem[rfcp_pkg::POS_W-1:rfcp_pkg::BIT_W]);
            cnt_next    = '0;
            first_next  = 1'b1;
            state_next  = rfcp_pkg::ST_SCAN;
          end
        end
      end
      rfcp_pkg::ST_SCAN: begin
        if (cand != '0) begin
          mem_we    = 1'b1;
          mem_wdata = rdata | (rfcp_pkg::WORD_BITS'(1) << fbit);
          pos_next  = pos_found;
          if (line_width == '0) begin
            emit       = 1'b1;
            o_idx      = rfcp_pkg::OUT_W'(pos_found);
            o_col      = rfcp_pkg::OUT_W'(pos_found);
            state_next = rfcp_pkg::ST_IDLE;
          end else begin
            div_req.go       = 1'b1;
            div_req.dividend = rfcp_pkg::DIV_W'(pos_found);
            div_req.divisor  = line_width;
            state_next       = rfcp_pkg::ST_SPLIT;
          end
        end else if (cnt == nwr) begin
          emit       = 1'b1;
          o_none     = 1'b1;
          state_next = rfcp_pkg::ST_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          first_next = 1'b0;
          widx_next  = widx_adv;
          raddr      = WAW'(widx_adv);
        end
      end
      rfcp_pkg::ST_SPLIT: begin
        if (div_rsp.done) begin
          emit       = 1'b1;
          o_idx      = rfcp_pkg::OUT_W'(pos);
          o_col      = rfcp_pkg::OUT_W'(div_rsp.rem);
          o_row      = rfcp_pkg::OUT_W'(div_rsp.quot);
          state_next = rfcp_pkg::ST_IDLE;
        end
      end
      default: state_next = rfcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfcp_pkg::ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      clr_reply <= clr_reply_next;
      done      <= emit;
    end
  end

  always_ff @(posedge clk) begin
    widx   <= widx_next;
    bstart <= bstart_next;
    cnt    <= cnt_next;
    first  <= first_next;
    pos    <= pos_next;
    if (emit) begin
      cell_index <= o_idx;
      column     <= o_col;
      row        <= o_row;
      none_free  <= o_none;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

// File: src/rfcp_checker.sv
module rfcp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [rfcp_pkg::OUT_W-1:0] cell_index,
  input logic [rfcp_pkg::OUT_W-1:0] column,
  input logic [rfcp_pkg::OUT_W-1:0] row,
  input logic                       none_free
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("map sweep not running after reset");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside end of command");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && none_free) |-> (cell_index == '0 && column == '0 && row == '0))
    else $error("full map result carries a cell");

endmodule

bind random_free_cell_picker rfcp_checker u_rfcp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .cell_index (cell_index),
  .column     (column),
  .row        (row),
  .none_free  (none_free)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int CELLS       = 16384;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 600;
  localparam int RAND_ITEMS  = 1000;

  typedef struct packed {
    logic [rfcp_pkg::OUT_W-1:0] cell_index;
    logic [rfcp_pkg::OUT_W-1:0] column;
    logic [rfcp_pkg::OUT_W-1:0] row;
    logic                       none_free;
  } cell_result_t;

  class cell_scoreboard;
    bit [CELLS-1:0]             visited;
    logic [rfcp_pkg::CFG_W-1:0] line_width;
    logic [rfcp_pkg::CFG_W-1:0] region;
    cell_result_t               expected[$];
    int                         errors;

    function new();
      visited    = '0;
      line_width = rfcp_pkg::CFG_W'(128);
      region     = rfcp_pkg::CFG_W'(16384);
      errors     = 0;
    endfunction

    function int unsigned span();
      return (region > CELLS) ? CELLS : region;
    endfunction

    function void set_register(logic idx, logic [rfcp_pkg::CFG_W-1:0] data);
      if (idx == rfcp_pkg::REG_LINE_WIDTH) begin
        line_width = data;
      end else begin
        region = data;
      end
    endfunction

    function void note_command(logic op, logic [rfcp_pkg::RAND_W-1:0] rnd);
      cell_result_t r;
      int unsigned  cells;
      int unsigned  pos;
      int unsigned  n;
      bit           found;
      r = '0;
      found = 0;
      cells = span();
      if (op == rfcp_pkg::OP_CLEAR) begin
        visited = '0;
      end else if (cells == 0) begin
        r.none_free = 1'b1;
      end else begin
        pos = rnd % cells;
        for (n = 0; n < cells && !found; n++) begin
          if (!visited[pos]) begin
            visited[pos] = 1'b1;
            found = 1;
            r.cell_index = pos[rfcp_pkg::OUT_W-1:0];
            if (line_width == 0) begin
              r.column = pos[rfcp_pkg::OUT_W-1:0];
              r.row    = '0;
            end else begin
              r.column = rfcp_pkg::OUT_W'(pos % line_width);
              r.row    = rfcp_pkg::OUT_W'(pos / line_width);
            end
          end else begin
            pos++;
            if (pos == cells) pos = 0;
          end
        end
        if (!found) r.none_free = 1'b1;
      end
      expected.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(cell_result_t got);
      cell_result_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending, cell_index %0d", got.cell_index));
        return;
      end
      want = expected.pop_front();
      if (got.cell_index !== want.cell_index)
        report_mismatch($sformatf("cell_index %0d, want %0d", got.cell_index, want.cell_index));
      if (got.column !== want.column)
        report_mismatch($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.row !== want.row)
        report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.none_free !== want.none_free)
        report_mismatch($sformatf("none_free %0b, want %0b", got.none_free, want.none_free));
    endtask
  endclass

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        start        = 1'b0;
  logic                        busy;
  logic                        opcode       = rfcp_pkg::OP_PICK;
  logic [rfcp_pkg::RAND_W-1:0] random_value = '0;
  logic                        done;
  logic [rfcp_pkg::OUT_W-1:0]  cell_index;
  logic [rfcp_pkg::OUT_W-1:0]  column;
  logic [rfcp_pkg::OUT_W-1:0]  row;
  logic                        none_free;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index    = rfcp_pkg::REG_LINE_WIDTH;
  logic [rfcp_pkg::CFG_W-1:0]  cfg_data     = '0;

  cell_scoreboard sb = new();
  int             idle_pct = 0;
  int             quiet_cycles = 0;

  random_free_cell_picker #(
    .MAX_CELLS(CELLS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .random_value(random_value),
    .done        (done),
    .cell_index  (cell_index),
    .column      (column),
    .row         (row),
    .none_free   (none_free),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result({cell_index, column, row, none_free});
      if (start && !busy) sb.note_command(opcode, random_value);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_command(logic op, logic [rfcp_pkg::RAND_W-1:0] rnd);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    opcode       <= op;
    random_value <= rnd;
    do @(posedge clk); while (busy);
  endtask

  task end_burst();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task drain();
    while (sb.expected.size() != 0) @(negedge clk);
  endtask

  task write_reg(logic idx, logic [rfcp_pkg::CFG_W-1:0] data);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task run_directed();
    send_command(rfcp_pkg::OP_PICK, '0);
    send_command(rfcp_pkg::OP_PICK, '0);
    send_command(rfcp_pkg::OP_PICK, '1);
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(16383));
    send_command(rfcp_pkg::OP_CLEAR, '1);
    send_command(rfcp_pkg::OP_PICK, '0);
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_LINE_WIDTH, '0);
    write_reg(rfcp_pkg::REG_REGION, rfcp_pkg::CFG_W'(3));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(5));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(2));
    send_command(rfcp_pkg::OP_PICK, '0);
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_REGION, '0);
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(123));
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_REGION, '1);
    write_reg(rfcp_pkg::REG_LINE_WIDTH, '1);
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(3));
    send_command(rfcp_pkg::OP_PICK, '1);
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_REGION, rfcp_pkg::CFG_W'(4));
    write_reg(rfcp_pkg::REG_LINE_WIDTH, rfcp_pkg::CFG_W'(1));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(1));
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_REGION, rfcp_pkg::CFG_W'(20));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(3));
    send_command(rfcp_pkg::OP_CLEAR, '0);
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_LINE_WIDTH, rfcp_pkg::CFG_W'(16384));
    write_reg(rfcp_pkg::REG_REGION, rfcp_pkg::CFG_W'(1));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'('h5555_5555));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'('h2AAA_AAAA));
    end_burst();
    drain();
    write_reg(rfcp_pkg::REG_LINE_WIDTH, rfcp_pkg::CFG_W'(7));
    write_reg(rfcp_pkg::REG_REGION, rfcp_pkg::CFG_W'(16384));
    send_command(rfcp_pkg::OP_PICK, rfcp_pkg::RAND_W'(16383));
    end_burst();
    drain();
  endtask

  initial begin
    int                          sent;
    int                          phase;
    int                          burst;
    int                          sel;
    int unsigned                 cells;
    logic                        op;
    logic [rfcp_pkg::RAND_W-1:0] rnd;
    logic [rfcp_pkg::CFG_W-1:0]  lw;
    logic [rfcp_pkg::CFG_W-1:0]  reg_cells;
    sent  = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    while (sent < RAND_ITEMS) begin
      idle_pct = (phase >= 8 && phase < 14) ? 0 : 9;
      sel = $urandom_range(9);
      if (sel <= 5) begin
        reg_cells = rfcp_pkg::CFG_W'($urandom_range(1, 48));
        lw        = rfcp_pkg::CFG_W'($urandom_range(0, 12));
      end else if (sel <= 7) begin
        reg_cells = rfcp_pkg::CFG_W'($urandom_range(49, 2048));
        lw        = rfcp_pkg::CFG_W'($urandom_range(1, 200));
      end else if (sel == 8) begin
        reg_cells = rfcp_pkg::CFG_W'($urandom_range(16384, 32767));
        lw        = rfcp_pkg::CFG_W'($urandom_range(0, 32767));
      end else begin
        reg_cells = rfcp_pkg::CFG_W'($urandom_range(0, 32767));
        lw        = rfcp_pkg::CFG_W'($urandom_range(0, 32767));
      end
      if ($urandom_range(3) != 0) write_reg(rfcp_pkg::REG_REGION, reg_cells);
      if ($urandom_range(3) != 0) write_reg(rfcp_pkg::REG_LINE_WIDTH, lw);
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        cells = sb.span();
        op  = ($urandom_range(99) < 5) ? rfcp_pkg::OP_CLEAR : rfcp_pkg::OP_PICK;
        rnd = ($urandom_range(3) == 0) ? rfcp_pkg::RAND_W'($urandom_range(0, 2 * cells))
                                       : rfcp_pkg::RAND_W'($urandom);
        send_command(op, rnd);
      end
      end_burst();
      drain();
      sent += burst;
      phase++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
